// ----- rtl/pphm_pkg.sv -----
// shared types, constants and register codes for the histogram-mode background block
package pphm_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;
    localparam int COUNT_BITS   = 16;

    localparam int PIX_BITS   = 12;
    localparam int PIX_LIMIT  = 2 ** PIX_BITS;
    localparam int BIN_BITS   = 8;
    localparam int NUM_BINS   = 2 ** BIN_BITS;
    localparam int FC_BITS    = 32;
    localparam int PERIOD_BITS = 16;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd30;

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    // register index taken from paddr[2]
    typedef enum logic {
        REG_UPDATE_PERIOD = 1'b0,
        REG_NONE          = 1'b1
    } t_reg;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_index;
        logic [BIN_BITS-1:0] hue;
        logic                excluded;
        logic                frame_end;
    } t_in;

    typedef struct packed {
        logic                background_valid;
        logic [BIN_BITS-1:0] background_hue;
        logic [PIX_BITS-1:0] out_pixel_index;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic accept;
        logic rd_hue;
        logic upd;
        logic scan_init;
        logic scan_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic rem_busy;
        logic in_range;
        logic est;
        logic scan_last;
        logic slot_free;
    } t_sts;

endpackage

// ----- rtl/pphm_ram.sv -----
// generic simple dual-port ram with registered read
module pphm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pphm_rem.sv -----
// bit-serial remainder unit, flags a nonzero frame count that the period divides
module pphm_rem (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pphm_pkg::FC_BITS-1:0]       i_dividend,
    input  logic [pphm_pkg::PERIOD_BITS-1:0]   i_divisor,
    output logic                               o_busy,
    output logic                               o_est
);

    localparam int STEPS = pphm_pkg::FC_BITS;
    localparam int CNT_W = $clog2(STEPS);
    localparam int PW    = pphm_pkg::PERIOD_BITS;

    logic             r_busy, n_busy;
    logic             r_est, n_est;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [STEPS-1:0] r_quo, n_quo;
    logic [PW-1:0]    r_div, n_div;
    logic [PW-1:0]    r_rem, n_rem;
    logic             r_nz, n_nz;
    logic [PW:0]      trial;
    logic [PW:0]      diff;

    always_comb begin
        trial  = {r_rem, r_quo[STEPS-1]};
        diff   = trial - {1'b0, r_div};
        n_busy = r_busy;
        n_est  = r_est;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_div  = r_div;
        n_rem  = r_rem;
        n_nz   = r_nz;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(STEPS - 1);
            n_quo  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
            n_nz   = (i_dividend != '0) && (i_divisor != '0);
        end else if (r_busy) begin
            n_rem = (trial >= {1'b0, r_div}) ? diff[PW-1:0] : trial[PW-1:0];
            n_quo = {r_quo[STEPS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_est  = r_nz && (n_rem == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_est  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_est  <= n_est;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_div <= n_div;
        r_rem <= n_rem;
        r_nz  <= n_nz;
    end

    assign o_busy = r_busy;
    assign o_est  = r_est;

endmodule

// ----- rtl/pphm_dp.sv -----
// datapath: histogram ram, item and scan registers, frame counter, period, output register
module pphm_dp #(
    parameter int FRAME_WIDTH  = pphm_pkg::FRAME_WIDTH,
    parameter int FRAME_HEIGHT = pphm_pkg::FRAME_HEIGHT,
    parameter int COUNT_BITS   = pphm_pkg::COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pphm_pkg::t_cmd                   i_cmd,
    output pphm_pkg::t_sts                   o_sts,
    input  pphm_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pphm_pkg::t_out                   o_out,
    input  logic                             i_cfg_wr,
    input  logic [pphm_pkg::PERIOD_BITS-1:0] i_cfg_data,
    output logic [pphm_pkg::PERIOD_BITS-1:0] o_period
);

    localparam int NUM_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int MEM_PIXELS = (NUM_PIXELS < pphm_pkg::PIX_LIMIT) ?
                                NUM_PIXELS : pphm_pkg::PIX_LIMIT;
    localparam int DEPTH      = MEM_PIXELS * pphm_pkg::NUM_BINS;
    localparam int AW         = $clog2(DEPTH);
    localparam int BB         = pphm_pkg::BIN_BITS;
    localparam int PB         = pphm_pkg::PIX_BITS;
    localparam int SB         = BB + 1;
    localparam int FB         = pphm_pkg::FC_BITS;

    pphm_pkg::t_in             r_item;
    logic                      r_est_item;
    logic [AW-1:0]             r_clr;
    logic [SB-1:0]             r_scan;
    logic [COUNT_BITS-1:0]     r_best_cnt;
    logic [BB-1:0]             r_best_hue;
    logic [FB-1:0]             r_fc;
    logic [pphm_pkg::PERIOD_BITS-1:0] r_period;
    logic                      r_out_valid;
    pphm_pkg::t_out            r_out;

    logic                      we;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             raddr;
    logic [COUNT_BITS-1:0]     wdata;
    logic [COUNT_BITS-1:0]     rdata;
    logic [BB-1:0]             cons_bin;
    logic                      in_range;
    logic                      frame_inc;
    logic                      rem_start;
    logic                      rem_busy;
    logic                      rem_est;
    logic                      bg_valid;
    logic [FB-1:0]             fc_next;

    function automatic logic [AW-1:0] bin_addr(input logic [PB-1:0] pix,
                                               input logic [BB-1:0] bin);
        logic [PB+BB-1:0] full;
        full = {pix, bin};
        return full[AW-1:0];
    endfunction

    assign in_range = {{(FB-PB){1'b0}}, r_item.pixel_index} < FB'(NUM_PIXELS);
    assign cons_bin = BB'(r_scan - 1'b1);

    // ram port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_clr;
        wdata = '0;
        raddr = bin_addr(r_item.pixel_index, r_scan[BB-1:0]);
        priority if (i_cmd.clr_en) begin
            we = 1'b1;
        end else if (i_cmd.rd_hue) begin
            raddr = bin_addr(r_item.pixel_index, r_item.hue);
        end else if (i_cmd.upd) begin
            we    = 1'b1;
            waddr = bin_addr(r_item.pixel_index, r_item.hue);
            wdata = (!r_item.excluded && (rdata != '1)) ? rdata + 1'b1 : rdata;
        end else if (i_cmd.scan_step) begin
            // clear the bin whose count is consumed this cycle
            we    = (r_scan != '0);
            waddr = bin_addr(r_item.pixel_index, cons_bin);
        end else begin
            we = 1'b0;
        end
    end

    pphm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign frame_inc = i_cmd.finish && r_item.frame_end;
    assign fc_next   = frame_inc ? r_fc + 1'b1 : r_fc;
    assign rem_start = frame_inc || i_cfg_wr;

    pphm_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (fc_next),
        .i_divisor  (i_cfg_wr ? i_cfg_data : r_period),
        .o_busy     (rem_busy),
        .o_est      (rem_est)
    );

    assign bg_valid = in_range && r_est_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_scan      <= '0;
            r_fc        <= '0;
            r_period    <= pphm_pkg::PERIOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_scan <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
            end
            r_fc <= fc_next;
            if (i_cfg_wr) begin
                r_period <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item     <= i_in;
            r_est_item <= rem_est;
        end
        if (i_cmd.scan_step && (r_scan != '0)) begin
            if ((r_scan == SB'(1)) || (rdata > r_best_cnt)) begin
                r_best_cnt <= rdata;
                r_best_hue <= cons_bin;
            end
        end
        if (i_cmd.finish) begin
            r_out.background_valid <= bg_valid;
            r_out.background_hue   <= bg_valid ? r_best_hue : '0;
            r_out.out_pixel_index  <= r_item.pixel_index;
        end
    end

    assign o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_sts.rem_busy  = rem_busy;
    assign o_sts.in_range  = in_range;
    assign o_sts.est       = r_est_item;
    assign o_sts.scan_last = (r_scan == SB'(pphm_pkg::NUM_BINS));
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_period    = r_period;

endmodule

// ----- rtl/pphm_ctrl.sv -----
// controller state machine sequencing clear pass, bin update and mode scan
module pphm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pphm_pkg::t_sts i_sts,
    output pphm_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_SCAN   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = !i_sts.rem_busy;
                if (i_in_valid && !i_sts.rem_busy) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_hue = 1'b1;
                n_state      = i_sts.in_range ? S_UPDATE : S_DONE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                if (i_sts.est) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/per_pixel_histogram_mode_background_top.sv -----
// top level of the per-pixel histogram-mode background estimator
//
// each request carries one hue pixel with its index, an exclusion flag and an
// end-of-frame mark, and gives exactly one result with the echoed index.
// every pixel owns a 256-bin histogram of saturating counts held in a single
// ram of FRAME_WIDTH*FRAME_HEIGHT*256 words (at most 4096 pixels); in a frame
// whose number is a nonzero multiple of update_period the pixel reports its
// most frequent hue (lowest hue on ties) and its histogram is cleared.
// after reset a clearing pass writes zero to every ram word, one per cycle,
// during which no request is taken; update_period can be written meanwhile.
// each pixel passes accept, bin read, write-back and result; a pixel in an
// estimate frame also scans its 256 bins through the single ram read port,
// and an out-of-range pixel skips the write-back. a new pixel is taken only
// once the last one's result is in the output register. after the last
// pixel of a frame, or after a write to update_period, the estimate flag
// is recomputed by a bit-serial remainder unit before the next request is
// taken. results sit in an output register, so the next request is taken
// while a result still waits. register update_period lies at byte address 0.
module per_pixel_histogram_mode_background_top #(
    parameter int FRAME_WIDTH  = pphm_pkg::FRAME_WIDTH,
    parameter int FRAME_HEIGHT = pphm_pkg::FRAME_HEIGHT,
    parameter int COUNT_BITS   = pphm_pkg::COUNT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pphm_pkg::t_in                      i_in,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pphm_pkg::t_out                     o_out,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pphm_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [pphm_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [pphm_pkg::PDATA_BITS-1:0]    prdata,
    output logic                               pready
);

    pphm_pkg::t_cmd                   cmd;
    pphm_pkg::t_sts                   sts;
    pphm_pkg::t_reg                   reg_sel;
    logic                             cfg_wr;
    logic [pphm_pkg::PERIOD_BITS-1:0] period;

    // register decode, word index from paddr[2]
    assign reg_sel = pphm_pkg::t_reg'(paddr[2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (reg_sel == pphm_pkg::REG_UPDATE_PERIOD);

    always_comb begin
        unique case (reg_sel)
            pphm_pkg::REG_UPDATE_PERIOD: begin
                prdata = {{(pphm_pkg::PDATA_BITS - pphm_pkg::PERIOD_BITS){1'b0}}, period};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // sequencing of clear pass, per-pixel update and mode scan
    pphm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // histogram ram, frame counter, remainder unit and output register
    pphm_dp #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_data  (pwdata[pphm_pkg::PERIOD_BITS-1:0]),
        .o_period    (period)
    );

`ifndef SYNTHESIS
    // no request is taken while the ram is still being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_en |-> !o_in_ready)
        else $error("request taken during clearing pass");

    // the estimate flag must be settled before a request is taken
    a_no_accept_rem_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.rem_busy |-> !o_in_ready)
        else $error("request taken while remainder unit busy");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !cmd.finish)
        else $error("result register overwritten");

    // a result without an estimate reports hue zero
    a_zero_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.background_valid) |-> (o_out.background_hue == '0))
        else $error("nonzero hue without estimate");
`endif

endmodule

// ----- test/testbench.sv -----
// testbench for the per-pixel histogram-mode background estimator: predicted results vs the block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // size of the pixel plane and of one saturated count
    localparam int NUM_PIXELS = pphm_pkg::FRAME_WIDTH * pphm_pkg::FRAME_HEIGHT;
    localparam logic [pphm_pkg::COUNT_BITS-1:0] COUNT_TOP = {pphm_pkg::COUNT_BITS{1'b1}};

    // quiet cycles allowed: the clearing pass after reset takes no request,
    // so the limit sits above the length of that pass
    localparam int QUIET_LIMIT = 3_200_000;

    // receiver holds off for a long stretch at these result counts
    localparam int HOLD_AT_FIRST  = 40;
    localparam int HOLD_AT_SECOND = 700;
    localparam int LONG_HOLD      = 500;

    localparam int PHASE_ITEMS = 250;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    pphm_pkg::t_in  i_in = '0;

    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    pphm_pkg::t_out o_out;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [pphm_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [pphm_pkg::PDATA_BITS-1:0] pwdata = '0;
    logic [pphm_pkg::PDATA_BITS-1:0] prdata;
    logic                            pready;

    per_pixel_histogram_mode_background_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // predictor state: every pixel's bins, the frame number and the period
    bit [pphm_pkg::COUNT_BITS-1:0]  bin_counts [NUM_PIXELS*pphm_pkg::NUM_BINS];
    bit [pphm_pkg::FC_BITS-1:0]     frames_seen = '0;
    bit [pphm_pkg::PERIOD_BITS-1:0] period_reg = pphm_pkg::PERIOD_RESET;

    // pixel requests waiting for the driver, and results still to come
    pphm_pkg::t_in  pending_pixels [$];
    pphm_pkg::t_out bg_expected [$];

    // handshake bookkeeping shared by driver, receiver and monitor
    int  reqs_offered = 0;
    int  reqs_taken = 0;
    int  results_taken = 0;
    int  results_seen = 0;
    int  req_gap = 0;
    int  res_gap = 0;
    bit  no_gaps = 1'b0;
    int  quiet_cycles = 0;
    int  mismatches = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // work out the result of one accepted pixel and advance the model
    function automatic void predict_background(input pphm_pkg::t_in px);
        int                            base;
        int                            best;
        bit [pphm_pkg::COUNT_BITS-1:0] best_count;
        bit                            estimate_frame;
        pphm_pkg::t_out                res;
        estimate_frame = frames_seen != 0 && period_reg != 0 &&
                         (frames_seen % period_reg) == 0;
        res = '0;
        res.out_pixel_index = px.pixel_index;
        if (int'(px.pixel_index) < NUM_PIXELS) begin
            base = int'(px.pixel_index) * pphm_pkg::NUM_BINS;
            // saturating count, excluded pixels leave the bins alone
            if (!px.excluded && bin_counts[base + px.hue] != COUNT_TOP) begin
                bin_counts[base + px.hue] = bin_counts[base + px.hue] + 1'b1;
            end
            if (estimate_frame) begin
                // strict greater keeps the lowest hue on a tie
                best = 0;
                best_count = bin_counts[base];
                for (int b = 1; b < pphm_pkg::NUM_BINS; b++) begin
                    if (bin_counts[base + b] > best_count) begin
                        best_count = bin_counts[base + b];
                        best = b;
                    end
                end
                for (int b = 0; b < pphm_pkg::NUM_BINS; b++) begin
                    bin_counts[base + b] = '0;
                end
                res.background_valid = 1'b1;
                res.background_hue = best[pphm_pkg::BIN_BITS-1:0];
            end
        end
        // the frame number moves on after the last pixel is handled
        if (px.frame_end) begin
            frames_seen = frames_seen + 1'b1;
        end
        bg_expected.insert(bg_expected.size(), res);
    endfunction

    task automatic queue_pixel(input logic [pphm_pkg::PIX_BITS-1:0] pix,
                               input logic [pphm_pkg::BIN_BITS-1:0] hue,
                               input logic excl, input logic fend);
        pphm_pkg::t_in px;
        px.pixel_index = pix;
        px.hue = hue;
        px.excluded = excl;
        px.frame_end = fend;
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    // random frames over a small pool of pixels and hues, so histograms
    // build up competing counts and ties, with some fully random pixels
    task automatic queue_random_phase(input int count);
        logic [pphm_pkg::PIX_BITS-1:0] pix_pool [6];
        logic [pphm_pkg::BIN_BITS-1:0] hue_pool [4];
        logic [pphm_pkg::PIX_BITS-1:0] pix;
        logic [pphm_pkg::BIN_BITS-1:0] hue;
        logic                          excl;
        logic                          fend;
        for (int i = 0; i < 6; i++) begin
            pix_pool[i] = pphm_pkg::PIX_BITS'($urandom);
        end
        for (int i = 0; i < 4; i++) begin
            hue_pool[i] = pphm_pkg::BIN_BITS'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99, 0) < 85) begin
                pix = pix_pool[$urandom_range(5, 0)];
            end else begin
                pix = pphm_pkg::PIX_BITS'($urandom);
            end
            if ($urandom_range(99, 0) < 70) begin
                hue = hue_pool[$urandom_range(3, 0)];
            end else begin
                hue = pphm_pkg::BIN_BITS'($urandom);
            end
            excl = $urandom_range(5, 0) == 0;
            fend = $urandom_range(9, 0) == 0;
            queue_pixel(pix, hue, excl, fend);
        end
    endtask

    // block is idle once every request went in and every result came back
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || i_in_valid || reqs_offered != reqs_taken ||
               bg_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // apb write of update_period, only while the block is idle; the pause
    // covers the remainder unit that reruns after a frame end; a read back
    // follows the write
    task automatic write_period(input logic [pphm_pkg::PERIOD_BITS-1:0] value);
        logic [pphm_pkg::PDATA_BITS-pphm_pkg::PERIOD_BITS-1:0] junk;
        junk = (pphm_pkg::PDATA_BITS-pphm_pkg::PERIOD_BITS)'($urandom);
        wait_drained();
        repeat (64) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {pphm_pkg::REG_UPDATE_PERIOD, 2'b00};
        pwdata = {junk, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        period_reg = value;
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(pphm_pkg::PDATA_BITS-pphm_pkg::PERIOD_BITS){1'b0}}, value}) begin
            report_mismatch($sformatf("update_period read %0h want %0h", prdata, value));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // request driver: drops valid once taken, waits its gap, offers the next
    always @(negedge i_clk) begin
        logic          next_valid;
        pphm_pkg::t_in next_req;
        next_valid = i_in_valid;
        next_req = i_in;
        if (i_in_valid && reqs_taken == reqs_offered) begin
            next_valid = 1'b0;
            req_gap = no_gaps ? 0 : $urandom_range(10, 0);
        end
        if (!next_valid && i_rst_n) begin
            if (req_gap != 0) begin
                req_gap--;
            end else if (pending_pixels.size() != 0) begin
                next_req = pending_pixels.pop_front();
                next_valid = 1'b1;
                reqs_offered++;
            end
        end
        i_in_valid <= next_valid;
        i_in <= next_req;
    end

    // result receiver: after each result it stalls for a drawn gap, and at
    // two points for a long stretch so the block fills and backs up
    always @(negedge i_clk) begin
        logic next_ready;
        next_ready = i_out_ready;
        if (i_out_ready && results_taken != results_seen) begin
            results_seen = results_taken;
            next_ready = 1'b0;
            if (results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_SECOND) begin
                res_gap = LONG_HOLD;
            end else begin
                res_gap = no_gaps ? 0 : $urandom_range(10, 0);
            end
        end
        if (!next_ready) begin
            if (res_gap != 0) begin
                res_gap--;
            end else begin
                next_ready = 1'b1;
            end
        end
        i_out_ready <= next_ready;
    end

    // monitor: predict on every taken request, check every taken result
    always @(posedge i_clk) begin
        pphm_pkg::t_out want;
        if (i_rst_n) begin
            // predict first so a same-edge result still finds its entry
            if (i_in_valid && o_in_ready) begin
                predict_background(i_in);
                reqs_taken <= reqs_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                results_taken <= results_taken + 1;
                if (bg_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result for pixel %0d",
                                              o_out.out_pixel_index));
                end else begin
                    want = bg_expected.pop_front();
                    if (o_out.background_valid !== want.background_valid) begin
                        report_mismatch($sformatf("background_valid got %b want %b (pixel %0d)",
                                                  o_out.background_valid,
                                                  want.background_valid,
                                                  want.out_pixel_index));
                    end
                    if (o_out.background_hue !== want.background_hue) begin
                        report_mismatch($sformatf("background_hue got %0d want %0d (pixel %0d)",
                                                  o_out.background_hue, want.background_hue,
                                                  want.out_pixel_index));
                    end
                    if (o_out.out_pixel_index !== want.out_pixel_index) begin
                        report_mismatch($sformatf("out_pixel_index got %0d want %0d",
                                                  o_out.out_pixel_index,
                                                  want.out_pixel_index));
                    end
                end
            end
        end
        // any handshake or register write counts as progress
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [pphm_pkg::PERIOD_BITS-1:0] phase_period [6];

        // synchronous reset, then the block clears its ram on its own
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset period: frame zero and the next two give no estimate, while
        // counts build up: a tie at pixel 7, another tie at pixel 9
        queue_pixel(12'd0, 8'd0, 1'b0, 1'b0);
        queue_pixel(12'd4095, 8'd255, 1'b0, 1'b0);
        queue_pixel(12'd7, 8'd200, 1'b0, 1'b0);
        queue_pixel(12'd7, 8'd100, 1'b0, 1'b0);
        queue_pixel(12'd9, 8'd50, 1'b0, 1'b0);
        queue_pixel(12'd11, 8'd77, 1'b1, 1'b1);
        queue_pixel(12'd9, 8'd50, 1'b0, 1'b0);
        queue_pixel(12'd9, 8'd10, 1'b0, 1'b0);
        queue_pixel(12'd9, 8'd10, 1'b0, 1'b1);
        queue_pixel(12'hAAA, 8'h55, 1'b0, 1'b0);
        queue_pixel(12'h555, 8'hAA, 1'b0, 1'b1);

        // period one: every frame estimates; excluded pixels still report,
        // an empty histogram reports hue zero, a repeat sees cleared bins
        write_period(16'd1);
        queue_pixel(12'd7, 8'd200, 1'b1, 1'b0);
        queue_pixel(12'd9, 8'd10, 1'b1, 1'b0);
        queue_pixel(12'd4095, 8'd255, 1'b0, 1'b0);
        queue_pixel(12'd0, 8'd255, 1'b1, 1'b0);
        queue_pixel(12'd11, 8'd0, 1'b1, 1'b0);
        queue_pixel(12'd7, 8'd33, 1'b0, 1'b0);
        queue_pixel(12'hAAA, 8'h55, 1'b0, 1'b1);

        // period zero: no frame estimates
        write_period(16'd0);
        queue_pixel(12'd7, 8'd1, 1'b0, 1'b0);
        queue_pixel(12'd7, 8'd1, 1'b0, 1'b1);

        // largest period
        write_period(16'hFFFF);
        queue_pixel(12'd100, 8'd128, 1'b0, 1'b1);
        queue_pixel(12'd3, 8'd3, 1'b1, 1'b1);

        // random phases across several periods, one of them with no gaps
        phase_period[0] = 16'd2;
        phase_period[1] = 16'd1;
        phase_period[2] = 16'd3;
        phase_period[3] = 16'd0;
        phase_period[4] = 16'hFFFF;
        phase_period[5] = pphm_pkg::PERIOD_BITS'($urandom_range(7, 4));
        for (int p = 0; p < 6; p++) begin
            write_period(phase_period[p]);
            no_gaps = (p == 2);
            queue_random_phase(PHASE_ITEMS);
        end

        // let the last results and the remainder unit settle
        wait_drained();
        no_gaps = 1'b0;
        repeat (64) @(posedge i_clk);
        if (bg_expected.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", bg_expected.size()));
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pphm_pkg.sv
rtl/pphm_ram.sv
rtl/pphm_rem.sv
rtl/pphm_dp.sv
rtl/pphm_ctrl.sv
rtl/per_pixel_histogram_mode_background_top.sv
test/testbench.sv
